// ===== sv/rtcm_pkg.sv =====
// Shared types and constants for the RGB tone curve mapper.
package rtcm_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int NUM_STAGES     = 7;
  localparam int NUM_BANKS      = 4;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 24;

  localparam logic [0:0] REG_CURVE_MODE    = 1'b0;
  localparam logic [0:0] REG_SEGMENT_COUNT = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic                  en;
    logic [5:0]            index;
    logic [7:0]            data;
  } rtcm_wr_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
    logic                  mode;
    logic [5:0]            n;
  } rtcm_ctl_t;

endpackage

// ===== sv/rtcm_bank.sv =====
// One bank of the control point table: points whose index mod 4 equals BANK.
module rtcm_bank
  import rtcm_pkg::*;
#(
  parameter int BANK = 0,
  parameter int RW   = 4
) (
  input  logic          clk,
  input  rtcm_wr_t      wr,
  input  logic          rd_en,
  input  logic [RW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0]    mem_r [2**RW];
  logic [8:0]    wrow;
  logic [RW-1:0] waddr;

  assign wrow  = 9'(wr.index >> 2);
  assign waddr = wrow[RW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en && (wr.index[1:0] == 2'(BANK))) begin
      mem_r[waddr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

// ===== sv/rtcm_lane.sv =====
// Per-channel datapath: segment split, point fetch, Horner evaluation, clamp.
module rtcm_lane
  import rtcm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk,
  input  rtcm_ctl_t ctl,
  input  rtcm_wr_t  wr,
  input  logic [7:0] c_in,
  output logic [7:0] c_out_r
);

  localparam int BD = (MAX_POINTS + NUM_BANKS - 1) / NUM_BANKS;
  localparam int RW = (BD > 1) ? $clog2(BD) : 1;

  // stage 1: segment and fraction
  logic [13:0]       prod;
  logic [13:0]       sq;
  logic [5:0]        seg;
  logic [13:0]       seg255;
  logic [7:0]        rem;
  logic signed [7:0] base;
  logic [5:0]        seg1_r;
  logic [7:0]        rem1_r;
  logic [7:0]        rd_data [NUM_BANKS];

  assign prod   = {6'b0, c_in} * {8'b0, ctl.n};
  assign sq     = (prod + (prod >> 8) + 14'd1) >> 8;
  assign seg    = sq[5:0];
  assign seg255 = {seg, 8'b0} - {8'b0, seg};
  assign rem    = 8'(prod - seg255);
  assign base   = $signed({2'b0, seg}) - 8'sd1;

  genvar b;
  generate
    for (b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [1:0]        kb;
      logic signed [7:0] idx;
      logic [8:0]        row;

      assign kb  = 2'(b) - base[1:0];
      assign idx = base + $signed({6'b0, kb});
      assign row = 9'(idx[7:2]);

      rtcm_bank #(.BANK(b), .RW(RW)) u_bank (
        .clk       (clk),
        .wr        (wr),
        .rd_en     (ctl.adv[1]),
        .rd_addr   (row[RW-1:0]),
        .rd_data_r (rd_data[b])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      seg1_r <= seg;
      rem1_r <= rem;
    end
  end

  // stage 2: align points, polynomial coefficients
  logic signed [7:0]  base1;
  logic signed [7:0]  pidx [NUM_BANKS];
  logic [7:0]         pval [NUM_BANKS];
  logic signed [13:0] pm, p0, p1, p2, d0, d1, a3, a2, dl;
  logic signed [13:0] a3_r, a2_r, d0_r, dl_r;
  logic [7:0]         y0_2_r;
  logic [15:0]        t2_r;

  assign base1 = $signed({2'b0, seg1_r}) - 8'sd1;

  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      pidx[k] = base1 + 8'(k);
      if (pidx[k][7] || (pidx[k] > $signed({2'b0, ctl.n}))) begin
        pval[k] = 8'd0;
      end else begin
        pval[k] = rd_data[pidx[k][1:0]];
      end
    end
    pm = $signed({6'b0, pval[0]});
    p0 = $signed({6'b0, pval[1]});
    p1 = $signed({6'b0, pval[2]});
    p2 = $signed({6'b0, pval[3]});
    d0 = p1 - pm;
    d1 = p2 - p0;
    dl = p1 - p0;
    a3 = ((p0 - p1) <<< 2) + d0 + d1;
    a2 = (dl <<< 2) + (dl <<< 1) - (d0 <<< 1) - d1;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      a3_r   <= a3;
      a2_r   <= a2;
      d0_r   <= d0;
      dl_r   <= dl;
      y0_2_r <= pval[1];
      t2_r   <= {rem1_r, rem1_r};
    end
  end

  // stage 3: first Horner step and linear blend
  logic signed [16:0] ts2;
  logic signed [31:0] q1;
  logic signed [25:0] lin;
  logic signed [31:0] q1_r;
  logic signed [25:0] lin3_r;
  logic signed [13:0] d0_3_r;
  logic [7:0]         y0_3_r;
  logic [15:0]        t3_r;

  assign ts2 = $signed({1'b0, t2_r});
  assign q1  = a3_r * ts2 + $signed({a2_r, 16'b0});
  assign lin = $signed({2'b0, y0_2_r, 16'b0}) + dl_r * ts2;

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      q1_r   <= q1;
      lin3_r <= lin;
      d0_3_r <= d0_r;
      y0_3_r <= y0_2_r;
      t3_r   <= t2_r;
    end
  end

  // stage 4: second Horner step
  logic signed [16:0] ts3;
  logic signed [48:0] q2;
  logic signed [48:0] q2_r;
  logic signed [25:0] lin4_r;
  logic [7:0]         y0_4_r;
  logic [15:0]        t4_r;

  assign ts3 = $signed({1'b0, t3_r});
  assign q2  = q1_r * ts3 + $signed({d0_3_r, 32'b0});

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      q2_r   <= q2;
      lin4_r <= lin3_r;
      y0_4_r <= y0_3_r;
      t4_r   <= t3_r;
    end
  end

  // stage 5: third step as two partial products
  logic signed [24:0] q2_hi;
  logic [23:0]        q2_lo;
  logic signed [41:0] phi;
  logic [39:0]        plo;
  logic signed [41:0] phi_r;
  logic [39:0]        plo_r;
  logic signed [25:0] lin5_r;
  logic [7:0]         y0_5_r;

  assign q2_hi = q2_r[48:24];
  assign q2_lo = q2_r[23:0];
  assign phi   = q2_hi * $signed({1'b0, t4_r});
  assign plo   = {16'b0, q2_lo} * {24'b0, t4_r};

  always_ff @(posedge clk) begin
    if (ctl.adv[5]) begin
      phi_r  <= phi;
      plo_r  <= plo;
      lin5_r <= lin4_r;
      y0_5_r <= y0_4_r;
    end
  end

  // stage 6: final sum, clamp, mode select
  logic signed [65:0] q3;
  logic [7:0]         cubic;

  assign q3 = $signed({phi_r, 24'b0}) + $signed({26'b0, plo_r})
            + $signed({9'b0, y0_5_r, 49'b0});

  always_comb begin
    if (q3[65]) begin
      cubic = 8'd0;
    end else if (|q3[64:57]) begin
      cubic = 8'hFF;
    end else begin
      cubic = q3[56:49];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[6]) begin
      c_out_r <= ctl.mode ? cubic : lin5_r[23:16];
    end
  end

endmodule

// ===== sv/rgb_tone_curve_mapper.sv =====
// Top level of the RGB tone curve mapper: ports, config, valid chain, lanes.
//
// Each pixel transfer is mapped through the loaded tone curve and its result
// is registered in seven register stages (input register plus six lane
// stages) of three channel lanes before it appears on out_tvalid/out_tdata.
// One pixel is taken every cycle unless the output stalls; an output stall
// holds the chain
// and fills bubbles first. Load transfers (tuser 0) write one control point
// into table banks replicated per lane and give no result; a pixel that
// follows a load sees the new point. Config writes are for an idle block only.
module rgb_tone_curve_mapper
  import rtcm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_index[5:0], point_value[13:6], red_in[21:14], green_in[29:22],
  // blue_in[37:30], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [5:0]            cfg_data
);

  logic                  mode_r;
  logic [5:0]            seg_cnt_r;
  logic [5:0]            n_act;
  logic [5:0]            n_min;
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] adv;
  logic [7:0]            chan_r [3];
  logic [7:0]            res [3];
  rtcm_ctl_t             ctl;
  rtcm_wr_t              wr;
  logic                  accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      seg_cnt_r <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CURVE_MODE:    mode_r    <= cfg_data[0];
        REG_SEGMENT_COUNT: seg_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_min = (seg_cnt_r == 6'd0) ? 6'd1 : seg_cnt_r;
    if (9'(n_min) > 9'(MAX_POINTS - 1)) begin
      n_act = 6'(MAX_POINTS - 1);
    end else begin
      n_act = n_min;
    end
  end

  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid && (in_tuser[0] == OP_PIXEL);
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      chan_r[0] <= in_tdata[21:14];
      chan_r[1] <= in_tdata[29:22];
      chan_r[2] <= in_tdata[37:30];
    end
  end

  assign wr.en    = accept && (in_tuser[0] == OP_LOAD)
                    && (9'(in_tdata[5:0]) < 9'(MAX_POINTS));
  assign wr.index = in_tdata[5:0];
  assign wr.data  = in_tdata[13:6];

  assign ctl.adv  = adv;
  assign ctl.mode = mode_r;
  assign ctl.n    = n_act;

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_lane
      rtcm_lane #(.MAX_POINTS(MAX_POINTS)) u_lane (
        .clk     (clk),
        .ctl     (ctl),
        .wr      (wr),
        .c_in    (chan_r[c]),
        .c_out_r (res[c])
      );
    end
  endgenerate

  assign out_tvalid = v_r[NUM_STAGES-1];
  assign out_tdata  = {res[2], res[1], res[0]};

endmodule

// ===== dv/rtcm_checker.sv =====
// Checker for the RGB tone curve mapper: watches transfers, predicts and compares results.
`timescale 1ns / 1ps
module rtcm_checker
  import rtcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [5:0]            cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  logic [7:0]  curve_pts [0:63];
  logic        cubic_mode;
  logic [5:0]  seg_count;
  logic [23:0] expected_pixels [$];

  function automatic longint point_at(longint i, int n);
    if (i < 0 || i > n) return 0;
    return longint'(curve_pts[i]);
  endfunction

  function automatic logic [7:0] map_level(logic [7:0] c, int n);
    longint prod, seg, rem, t, y0, y1, acc, t2, t3, s, h0, h1, h2, h3, d0, d1, total;
    if (c == 8'd255) return curve_pts[n];
    prod = longint'(c) * n;
    seg  = prod / 255;
    rem  = prod - seg * 255;
    t    = (rem << 16) / 255;
    y0   = point_at(seg, n);
    y1   = point_at(seg + 1, n);
    if (!cubic_mode) begin
      acc = y0 * (65536 - t) + y1 * t;
      return acc[23:16];
    end
    s  = 65536;
    t2 = t * t;
    t3 = t2 * t;
    h0 = 2 * t3 - 3 * t2 * s + s * s * s;
    h1 = 3 * t2 * s - 2 * t3;
    h2 = t3 - 2 * t2 * s + t * s * s;
    h3 = t3 - t2 * s;
    d0 = point_at(seg + 1, n) - point_at(seg - 1, n);
    d1 = point_at(seg + 2, n) - point_at(seg, n);
    total = 2 * y0 * h0 + 2 * y1 * h1 + d0 * h2 + d1 * h3;
    if (total < 0) return 8'd0;
    total = total >>> 49;
    if (total > 255) return 8'd255;
    return total[7:0];
  endfunction

  always @(posedge clk) begin
    int n;
    logic [23:0] want;
    if (!rst_n) begin
      cubic_mode <= 1'b0;
      seg_count  <= 6'd1;
      fail_count <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CURVE_MODE) cubic_mode <= cfg_data[0];
        else seg_count <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_LOAD) begin
          curve_pts[in_tdata[5:0]] = in_tdata[13:6];
        end else begin
          n = (seg_count == 0) ? 1 : seg_count;
          expected_pixels.push_back({map_level(in_tdata[37:30], n),
                                     map_level(in_tdata[29:22], n),
                                     map_level(in_tdata[21:14], n)});
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want !== out_tdata) begin
            if (fail_count < 10)
              $display("mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                       want[7:0], want[15:8], want[23:16],
                       out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_pixels.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the RGB tone curve mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import rtcm_pkg::*;

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid, cfg_ready;
  logic [0:0]            cfg_index;
  logic [5:0]            cfg_data;
  int                    fail_count, pending_count;
  int                    cycle_count;
  logic                  stall_enable;
  int                    active_n;

  rgb_tone_curve_mapper dut (.*);

  rtcm_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAIL rgb_tone_curve_mapper");
        $finish;
      end
    end
  end

  function automatic int gap_length();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(1, 3);
  endfunction

  // result side stalls
  initial begin
    int g;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_enable) out_tready <= 1'b1;
      else begin
        g = gap_length();
        if (g == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [5:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic op, logic [5:0] pidx, logic [7:0] pval,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = stall_enable ? gap_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, b, g, r, pval, pidx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic finish_items();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic load_curve(int n);
    for (int i = 0; i <= n; i++)
      send_item(OP_LOAD, i[5:0], 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    finish_items();
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_pixel();
    send_item(OP_PIXEL, 6'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int modes [4];
    int counts [4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_enable = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: full table, extremes, both modes
    active_n = 1;
    for (int i = 0; i < 64; i++)
      send_item(OP_LOAD, i[5:0], (i % 2) ? 8'hFF : 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PIXEL, 6'h3F, 8'hFF, 8'h00, 8'h80, 8'hFF);
    send_item(OP_PIXEL, 6'h00, 8'h00, 8'hFF, 8'h7F, 8'h01);
    drain();
    write_reg(REG_CURVE_MODE, 6'd1);
    write_reg(REG_SEGMENT_COUNT, 6'd63);
    send_item(OP_PIXEL, 6'h00, 8'h00, 8'h00, 8'h04, 8'hFF);
    send_item(OP_PIXEL, 6'h00, 8'h00, 8'h05, 8'hFB, 8'h80);
    drain();
    write_reg(REG_SEGMENT_COUNT, 6'd0);
    send_item(OP_PIXEL, 6'h00, 8'h00, 8'h00, 8'h80, 8'hFF);
    send_item(OP_PIXEL, 6'h00, 8'h00, 8'hAA, 8'h55, 8'hFE);
    drain();

    // random phases
    stall_enable = 1'b1;
    modes  = '{0, 1, 1, 0};
    counts = '{63, 1, 2, 63};
    for (int ph = 0; ph < 12; ph++) begin
      int n;
      n = (ph < 4) ? counts[ph] : $urandom_range(1, 63);
      write_reg(REG_CURVE_MODE, 6'((ph < 4) ? modes[ph] : $urandom_range(0, 1)));
      write_reg(REG_SEGMENT_COUNT, n[5:0]);
      load_curve(n);
      for (int k = 0; k < 85; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_LOAD, 6'($urandom_range(0, n)), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
        else random_pixel();
      end
      if (ph % 3 == 2) begin
        stall_enable = 1'b0;
        for (int k = 0; k < 30; k++) random_pixel();
        stall_enable = 1'b1;
      end
      drain();
    end

    if (fail_count == 0)
      $display("PASS rgb_tone_curve_mapper");
    else
      $display("FAIL rgb_tone_curve_mapper");
    $finish;
  end

endmodule
